@@ sv/beam_moment_twiss_analysis_top_defines.svh @@
// ----------------------------------------------------------------------------
// Beam moment analysis assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BEAM_MOMENT_TWISS_ANALYSIS_TOP_DEFINES_SVH
`define BEAM_MOMENT_TWISS_ANALYSIS_TOP_DEFINES_SVH
`ifndef SYNTH
`define BMT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BMT_ASSERT(lbl, prop, msg)
`define BMT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/bmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Beam moment analysis package
// Shared constants, types and fixed point helpers.
// ----------------------------------------------------------------------------
package bmt_pkg;
	localparam int COUNT_BITS = 16;
	localparam int COORD_BITS = 24;
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WINDOW_START = 2'd0,
		REG_WINDOW_END   = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_START,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_MEAN_E,
		OP_MA,
		OP_MB,
		OP_MAA,
		OP_MBB,
		OP_MAB,
		OP_VA,
		OP_VB,
		OP_C,
		OP_T,
		OP_DET,
		OP_SQRT,
		OP_EMIT,
		OP_BETA,
		OP_ALPHA
	} op_t;

	typedef logic signed [32:0] mul_op_t;
	typedef logic signed [65:0] mul_prod_t;

	localparam logic signed [33:0] VMAX34 = 34'sd2147483647;
	localparam logic signed [33:0] VMIN34 = -34'sd2147483647;

	// signed Q.32 -> Q.16, truncating toward zero, saturated
	function automatic logic signed [31:0] trunc_sat16(input logic signed [49:0] d);
		logic signed [49:0] adj;
		logic signed [33:0] sh;
		adj = d[49] ? d + 50'sd65535 : d;
		sh = adj[49:16];
		if (sh > VMAX34)
			return 32'sh7FFFFFFF;
		else if (sh < VMIN34)
			return 32'sh80000001;
		else
			return sh[31:0];
	endfunction
endpackage

@@ sv/beam_moment_twiss_analysis_top.sv @@
// ----------------------------------------------------------------------------
// Beam moment and Twiss analysis
// Windowed moment sums per sample; means, emittance, beta and alpha per set.
// ----------------------------------------------------------------------------
//  channel | signals                                  | role
//  in      | in_valid / in_ready, position .. last    | particle sample word
//  out     | out_valid / out_ready, sample_total ..   | result word per set
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata          | window bounds
//
//  A sample inside the window sends its six moment products one by one
//  through the shared 33x33 multiplier. The last sample of a non-empty set
//  then runs fifteen passes of the radix-2 divider plus two square roots.
//  in_ready is low while a word is in work or a result waits for out_ready.
//  Reset clears sums, count and windows (end window to all ones).
// ----------------------------------------------------------------------------
`include "beam_moment_twiss_analysis_top_defines.svh"

module beam_moment_twiss_analysis_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         position,
	input  logic signed [23:0]  coord_x,
	input  logic signed [23:0]  slope_x,
	input  logic signed [23:0]  coord_y,
	input  logic signed [23:0]  slope_y,
	input  logic [31:0]         energy,
	input  logic                last_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         sample_total,
	output logic [31:0]         energy_mean,
	output logic signed [23:0]  x_mean,
	output logic signed [23:0]  px_mean,
	output logic signed [23:0]  y_mean,
	output logic signed [23:0]  py_mean,
	output logic [47:0]         emit_x,
	output logic [47:0]         emit_y,
	output logic [39:0]         beta_x,
	output logic [39:0]         beta_y,
	output logic signed [31:0]  alpha_x,
	output logic signed [31:0]  alpha_y
);
	import bmt_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;
	logic   pl_q;
	logic [2:0] acc_step_q;

	logic [31:0] win_start_q, win_end_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [47:0] sum_e_q;
	logic signed [39:0] sum_x_q, sum_px_q, sum_y_q, sum_py_q;
	logic [63:0] sum_xx_q, sum_pxpx_q, sum_xpx_q, sum_yy_q, sum_pypy_q, sum_ypy_q;

	logic signed [COORD_BITS-1:0] x_q, px_q, y_q, py_q;
	logic last_q;

	logic [31:0] g_q;
	logic signed [23:0] ma_q, mb_q;
	logic [47:0] maa_q, mbb_q;
	logic signed [48:0] mab_q;
	logic signed [31:0] va_q, vb_q, c_q;
	logic signed [63:0] t_q;
	logic [63:0] mag_q;
	logic [31:0] s_q;
	logic [47:0] emit_q;
	logic [39:0] beta_q;
	logic div_neg_q;

	logic [15:0] total_r;
	logic [31:0] emean_r;
	logic signed [23:0] xm_r, pxm_r, ym_r, pym_r;
	logic [47:0] ex_r, ey_r;
	logic [39:0] bx_r, by_r;
	logic signed [31:0] ax_r, ay_r;

	logic in_acc, incl, unit_done, last_op, clr_res, div_neg_d;
	logic mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
	mul_op_t mul_a, mul_b;
	mul_prod_t mul_p;
	logic [63:0] div_dividend, div_q;
	logic [31:0] div_divisor, sqrt_root;

	logic signed [39:0] sa, sb;
	logic [39:0] sa_mag, sb_mag;
	logic [63:0] saa, sbb;
	logic signed [63:0] sab;
	logic [63:0] sab_mag;
	logic [31:0] c_mag;
	logic signed [49:0] d_va, d_vb, d_c;
	logic signed [63:0] det;
	logic signed [31:0] alpha_v;

	function automatic logic signed [23:0] sat24(input logic [63:0] m, input logic neg);
		if (neg)
			return (m > 64'h80_0000) ? 24'sh800000 : -m[23:0];
		else
			return (m > 64'h7F_FFFF) ? 24'sh7FFFFF : m[23:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic [63:0] m, input logic neg);
		if (neg)
			return (m > 64'h8000_0000) ? 32'sh80000000 : -m[31:0];
		else
			return (m > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF : m[31:0];
	endfunction

	bmt_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	bmt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_q)
	);

	bmt_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(mag_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign in_acc    = in_valid && in_ready;
	assign incl      = (position > win_start_q) && (position < win_end_q) && (count_q != '1);
	assign unit_done = mul_done || div_done || sqrt_done;
	assign last_op   = (op_q == OP_ALPHA) && pl_q;

	assign sa      = pl_q ? sum_y_q : sum_x_q;
	assign sb      = pl_q ? sum_py_q : sum_px_q;
	assign saa     = pl_q ? sum_yy_q : sum_xx_q;
	assign sbb     = pl_q ? sum_pypy_q : sum_pxpx_q;
	assign sab     = pl_q ? sum_ypy_q : sum_xpx_q;
	assign sa_mag  = sa[39] ? -sa : sa;
	assign sb_mag  = sb[39] ? -sb : sb;
	assign sab_mag = sab[63] ? -sab : sab;
	assign c_mag   = c_q[31] ? -c_q : c_q;

	assign d_va = $signed({2'b00, maa_q}) - $signed(mul_p[49:0]);
	assign d_vb = $signed({2'b00, mbb_q}) - $signed(mul_p[49:0]);
	assign d_c  = 50'(mab_q) - $signed(mul_p[49:0]);
	assign det  = t_q - $signed(mul_p[63:0]);
	assign alpha_v = (emit_q == '0) ? '0 : sat32(div_q, div_neg_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (incl)
						state_d = ST_ACC;
					else if (last_sample)
						state_d = (count_q == '0) ? ST_DONE : ST_START;
				end
			end
			ST_ACC: begin
				if (acc_step_q == 3'd6)
					state_d = last_q ? ST_START : ST_IDLE;
			end
			ST_START: state_d = ST_WAIT;
			ST_WAIT: begin
				if (unit_done)
					state_d = last_op ? ST_DONE : ST_START;
			end
			ST_DONE: begin
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_start    = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = 32'(count_q);
		div_neg_d    = 1'b0;
		sqrt_start   = 1'b0;
		clr_res      = 1'b0;
		case (state_q)
			ST_IDLE: clr_res = in_acc && !incl && last_sample && (count_q == '0);
			ST_ACC: begin
				mul_start = (acc_step_q < 3'd6);
				case (acc_step_q)
					3'd0: begin mul_a = 33'(x_q); mul_b = 33'(x_q); end
					3'd1: begin mul_a = 33'(px_q); mul_b = 33'(px_q); end
					3'd2: begin mul_a = 33'(x_q); mul_b = 33'(px_q); end
					3'd3: begin mul_a = 33'(y_q); mul_b = 33'(y_q); end
					3'd4: begin mul_a = 33'(py_q); mul_b = 33'(py_q); end
					3'd5: begin mul_a = 33'(y_q); mul_b = 33'(py_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_START: begin
				case (op_q)
					OP_MEAN_E: begin div_start = 1'b1; div_dividend = 64'(sum_e_q); end
					OP_MA: begin
						div_start = 1'b1; div_dividend = 64'(sa_mag); div_neg_d = sa[39];
					end
					OP_MB: begin
						div_start = 1'b1; div_dividend = 64'(sb_mag); div_neg_d = sb[39];
					end
					OP_MAA: begin div_start = 1'b1; div_dividend = saa; end
					OP_MBB: begin div_start = 1'b1; div_dividend = sbb; end
					OP_MAB: begin
						div_start = 1'b1; div_dividend = sab_mag; div_neg_d = sab[63];
					end
					OP_VA: begin mul_start = 1'b1; mul_a = 33'(ma_q); mul_b = 33'(ma_q); end
					OP_VB: begin mul_start = 1'b1; mul_a = 33'(mb_q); mul_b = 33'(mb_q); end
					OP_C: begin mul_start = 1'b1; mul_a = 33'(ma_q); mul_b = 33'(mb_q); end
					OP_T: begin mul_start = 1'b1; mul_a = 33'(va_q); mul_b = 33'(vb_q); end
					OP_DET: begin mul_start = 1'b1; mul_a = 33'(c_q); mul_b = 33'(c_q); end
					OP_SQRT: sqrt_start = 1'b1;
					OP_EMIT: begin
						mul_start = 1'b1;
						mul_a = $signed({1'b0, s_q});
						mul_b = $signed({1'b0, g_q});
					end
					OP_BETA: begin
						div_start    = 1'b1;
						div_dividend = {17'b0, va_q[30:0], 16'b0};
						div_divisor  = s_q;
					end
					OP_ALPHA: begin
						div_start    = 1'b1;
						div_dividend = {16'b0, c_mag, 16'b0};
						div_divisor  = s_q;
						div_neg_d    = (c_q > 32'sd0);
					end
					default: div_start = 1'b0;
				endcase
			end
			default: clr_res = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_MEAN_E;
			pl_q        <= 1'b0;
			acc_step_q  <= '0;
			win_start_q <= '0;
			win_end_q   <= '1;
			count_q     <= '0;
			sum_e_q     <= '0;
			sum_x_q     <= '0;
			sum_px_q    <= '0;
			sum_y_q     <= '0;
			sum_py_q    <= '0;
			sum_xx_q    <= '0;
			sum_pxpx_q  <= '0;
			sum_xpx_q   <= '0;
			sum_yy_q    <= '0;
			sum_pypy_q  <= '0;
			sum_ypy_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				if (cfg_index == REG_WINDOW_START)
					win_start_q <= cfg_wdata;
				else if (cfg_index == REG_WINDOW_END)
					win_end_q <= cfg_wdata;
			end
			if (state_q == ST_IDLE || state_q == ST_ACC) begin
				op_q <= OP_MEAN_E;
				pl_q <= 1'b0;
			end else if (state_q == ST_WAIT && unit_done) begin
				if (op_q == OP_ALPHA) begin
					op_q <= OP_MA;
					pl_q <= 1'b1;
				end else begin
					op_q <= op_t'(op_q + 4'd1);
				end
			end
			if (in_acc) begin
				acc_step_q <= '0;
				if (incl) begin
					count_q  <= count_q + 1'b1;
					sum_e_q  <= sum_e_q + 48'(energy);
					sum_x_q  <= sum_x_q + 40'(coord_x);
					sum_px_q <= sum_px_q + 40'(slope_x);
					sum_y_q  <= sum_y_q + 40'(coord_y);
					sum_py_q <= sum_py_q + 40'(slope_y);
				end
			end else if (state_q == ST_ACC) begin
				acc_step_q <= acc_step_q + 3'd1;
				case (acc_step_q)
					3'd1: sum_xx_q   <= sum_xx_q + mul_p[63:0];
					3'd2: sum_pxpx_q <= sum_pxpx_q + mul_p[63:0];
					3'd3: sum_xpx_q  <= sum_xpx_q + mul_p[63:0];
					3'd4: sum_yy_q   <= sum_yy_q + mul_p[63:0];
					3'd5: sum_pypy_q <= sum_pypy_q + mul_p[63:0];
					3'd6: sum_ypy_q  <= sum_ypy_q + mul_p[63:0];
					default: sum_xx_q <= sum_xx_q;
				endcase
			end else if (state_q == ST_WAIT && unit_done && last_op) begin
				count_q    <= '0;
				sum_e_q    <= '0;
				sum_x_q    <= '0;
				sum_px_q   <= '0;
				sum_y_q    <= '0;
				sum_py_q   <= '0;
				sum_xx_q   <= '0;
				sum_pxpx_q <= '0;
				sum_xpx_q  <= '0;
				sum_yy_q   <= '0;
				sum_pypy_q <= '0;
				sum_ypy_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= coord_x;
			px_q   <= slope_x;
			y_q    <= coord_y;
			py_q   <= slope_y;
			last_q <= last_sample;
		end
		if (state_q == ST_START)
			div_neg_q <= div_neg_d;
		if (clr_res) begin
			total_r <= '0; emean_r <= '0;
			xm_r <= '0; pxm_r <= '0; ym_r <= '0; pym_r <= '0;
			ex_r <= '0; ey_r <= '0; bx_r <= '0; by_r <= '0; ax_r <= '0; ay_r <= '0;
		end
		if (state_q == ST_WAIT && unit_done) begin
			case (op_q)
				OP_MEAN_E: begin
					g_q     <= (div_q > 64'hFFFF_FFFF) ? '1 : div_q[31:0];
					emean_r <= (div_q > 64'hFFFF_FFFF) ? '1 : div_q[31:0];
					total_r <= 16'(count_q);
				end
				OP_MA: ma_q <= sat24(div_q, div_neg_q);
				OP_MB: mb_q <= sat24(div_q, div_neg_q);
				OP_MAA: maa_q <= (div_q > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : div_q[47:0];
				OP_MBB: mbb_q <= (div_q > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : div_q[47:0];
				OP_MAB: begin
					if (div_q > 64'h8000_0000_0000)
						mab_q <= div_neg_q ? -49'sh8000_0000_0000 : 49'sh8000_0000_0000;
					else
						mab_q <= div_neg_q ? -$signed({1'b0, div_q[47:0]})
							: $signed({1'b0, div_q[47:0]});
				end
				OP_VA: va_q <= trunc_sat16(d_va);
				OP_VB: vb_q <= trunc_sat16(d_vb);
				OP_C: c_q <= trunc_sat16(d_c);
				OP_T: t_q <= $signed(mul_p[63:0]);
				OP_DET: mag_q <= det[63] ? -det : det;
				OP_SQRT: s_q <= sqrt_root;
				OP_EMIT: emit_q <= mul_p[63:16];
				OP_BETA: begin
					if (emit_q == '0 || va_q <= 32'sd0)
						beta_q <= '0;
					else
						beta_q <= (div_q > 64'hFF_FFFF_FFFF) ? '1 : div_q[39:0];
				end
				OP_ALPHA: begin
					if (pl_q) begin
						ym_r <= ma_q; pym_r <= mb_q; ey_r <= emit_q; by_r <= beta_q;
						ay_r <= alpha_v;
					end else begin
						xm_r <= ma_q; pxm_r <= mb_q; ex_r <= emit_q; bx_r <= beta_q;
						ax_r <= alpha_v;
					end
				end
				default: s_q <= s_q;
			endcase
		end
	end

	assign sample_total = total_r;
	assign energy_mean  = emean_r;
	assign x_mean       = xm_r;
	assign px_mean      = pxm_r;
	assign y_mean       = ym_r;
	assign py_mean      = pym_r;
	assign emit_x       = ex_r;
	assign emit_y       = ey_r;
	assign beta_x       = bx_r;
	assign beta_y       = by_r;
	assign alpha_x      = ax_r;
	assign alpha_y      = ay_r;

	`BMT_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while result pending")
	`BMT_ASSERT(a_empty_sums, (count_q != '0) || (sum_x_q == '0 && sum_xx_q == '0 && sum_ypy_q == '0), "sums nonzero with zero count")
	`BMT_ASSERT_NEXT(a_clear_after_out, out_valid && out_ready, count_q == '0, "sums not cleared after result")
	`BMT_ASSERT(a_empty_result, !(out_valid && sample_total == '0) || (emit_x == '0 && beta_x == '0 && alpha_y == '0), "empty set gave nonzero result")
endmodule

@@ sv/bmt_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33x33 multiply with registered product and done flag.
// ----------------------------------------------------------------------------
module bmt_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bmt_pkg::mul_op_t  a,
	input  bmt_pkg::mul_op_t  b,
	output logic              done,
	output bmt_pkg::mul_prod_t prod
);
	import bmt_pkg::*;

	logic      done_q;
	mul_prod_t prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= a * b;
		end
	end

	assign done = done_q;
	assign prod = prod_q;
endmodule

@@ sv/bmt_div.sv @@
// ----------------------------------------------------------------------------
// Shared divider
// Radix-2 restoring unsigned divide, 64-bit by 32-bit, one bit per cycle.
// ----------------------------------------------------------------------------
module bmt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	import bmt_pkg::*;

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? diff[31:0] : trial[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ sv/bmt_sqrt.sv @@
// ----------------------------------------------------------------------------
// Shared square root
// Digit-by-digit floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module bmt_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	import bmt_pkg::*;

	logic [63:0] v_q;
	logic [31:0] root_q;
	logic [33:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] rem2;
	logic [35:0] trial;
	logic [35:0] diff;
	logic        ge;

	assign rem2  = {rem_q, v_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = rem2 - trial;
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[61:0], 2'b00};
			root_q <= {root_q[30:0], ge};
			rem_q  <= ge ? diff[33:0] : rem2[33:0];
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
